FILE: src/htfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_pkg
// constants and the crc-8 step shared by the humidity/temperature frame decoder
// ----------------------------------------------------------------------------
package htfd_pkg;

	localparam logic [7:0]  CRC_INIT    = 8'hFF;
	localparam logic [7:0]  CRC_POLY    = 8'h31;
	localparam logic [2:0]  POS_FIRST   = 3'd0;
	localparam logic [2:0]  LAST_POS    = 3'd6;
	localparam int unsigned RAW_W       = 20;
	localparam int unsigned FRAME_W     = 2 * RAW_W;
	localparam logic [9:0]  SCALE       = 10'd625;
	localparam logic [5:0]  HUM_OFFSET  = 6'd52;
	localparam logic [4:0]  TEMP_OFFSET = 5'd26;
	localparam logic [15:0] TEMP_BIAS   = 16'd5000;

	// one byte through the crc, msb first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: src/humidity_temperature_frame_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decoder
// assembles a seven-byte sensor frame, checks its crc-8 and scales the readings
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid, in_ready  | rx_byte, frame_start
//  out     | out_valid, out_ready| crc_ok, status_byte, humidity_raw,
//          |                     | temperature_raw, humidity_centi,
//          |                     | temperature_centi
//
//  one word accepted per cycle while in_ready is high; the crc step is unrolled across the byte
//  the seventh byte of a frame gives its result through two registered stages:
//  one stage for crc compare and raw fields, one for the two scaling multipliers
//  reset clears the frame position, the crc and both stage valids
//  a stalled output holds the result; the input keeps moving while either stage
//  has room, and the frame stage moves on only while the output stage has room
// ----------------------------------------------------------------------------
module humidity_temperature_frame_decoder
	import htfd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               frame_start,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    crc_ok,
	output logic [7:0]              status_byte,
	output logic [RAW_W-1:0]        humidity_raw,
	output logic [RAW_W-1:0]        temperature_raw,
	output logic [13:0]             humidity_centi,
	output logic signed [14:0]      temperature_centi
);

	logic [2:0]         byte_pos_q;
	logic [7:0]         crc_q;
	logic [7:0]         status_q;
	logic [FRAME_W-1:0] shift_q;

	logic               valid_s1;
	logic               crc_ok_s1;
	logic [7:0]         status_s1;
	logic [RAW_W-1:0]   hraw_s1;
	logic [RAW_W-1:0]   traw_s1;

	logic               in_fire;
	logic               s1_load;
	logic               s1_move;
	logic               out_free;
	logic [2:0]         pos_eff;
	logic [7:0]         crc_next;
	logic [30:0]        hum_prod;
	logic [30:0]        temp_prod;
	logic [15:0]        temp_diff;

	assign out_free = !out_valid || out_ready;
	assign s1_move  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		pos_eff = frame_start ? POS_FIRST : byte_pos_q;
		if (pos_eff > LAST_POS) begin
			pos_eff = POS_FIRST;
		end
	end

	assign s1_load  = in_fire && (pos_eff == LAST_POS);
	assign crc_next = crc8_byte((pos_eff == POS_FIRST) ? CRC_INIT : crc_q, rx_byte);

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= POS_FIRST;
			crc_q      <= CRC_INIT;
		end else if (in_fire) begin
			if (pos_eff == LAST_POS) begin
				byte_pos_q <= POS_FIRST;
				crc_q      <= CRC_INIT;
			end else begin
				byte_pos_q <= pos_eff + 3'd1;
				crc_q      <= crc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (pos_eff == POS_FIRST) begin
				status_q <= rx_byte;
				shift_q  <= '0;
			end else if (pos_eff != LAST_POS) begin
				shift_q  <= {shift_q[FRAME_W-9:0], rx_byte};
			end
		end
	end

	// frame stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			crc_ok_s1 <= (crc_q == rx_byte);
			status_s1 <= status_q;
			hraw_s1   <= shift_q[FRAME_W-1:RAW_W];
			traw_s1   <= shift_q[RAW_W-1:0];
		end
	end

	// scaling
	assign hum_prod  = 31'({1'b0, hraw_s1} + 21'(HUM_OFFSET)) * 31'(SCALE);
	assign temp_prod = 31'({1'b0, traw_s1} + 21'(TEMP_OFFSET)) * 31'(SCALE);
	assign temp_diff = temp_prod[30:15] - TEMP_BIAS;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_move) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			crc_ok            <= crc_ok_s1;
			status_byte       <= status_s1;
			humidity_raw      <= hraw_s1;
			temperature_raw   <= traw_s1;
			humidity_centi    <= hum_prod[29:16];
			temperature_centi <= signed'(temp_diff[14:0]);
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= LAST_POS)
		else $error("frame position out of range");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		s1_load |=> (byte_pos_q == POS_FIRST) && (crc_q == CRC_INIT) && valid_s1)
		else $error("frame state not restarted after last byte");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled with room in the pipeline");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |=> valid_s1 && $stable(hraw_s1))
		else $error("frame stage lost under stall");
`endif

endmodule
`default_nettype wire
